/* rtl/hwe_pkg.sv */
`default_nettype none
package hwe_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned TMO_W  = 20;
	localparam int unsigned VEL_W  = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned MASK_W = 3;

	typedef enum logic [2:0] {
		OP_ODOM  = 3'd0,
		OP_LOC   = 3'd1,
		OP_NAV   = 3'd2,
		OP_CHECK = 3'd3,
		OP_VEL   = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ODOM_TMO = 2'd0,
		REG_LOC_TMO  = 2'd1,
		REG_NAV_TMO  = 2'd2
	} reg_idx_t;

	localparam logic [TMO_W-1:0] ODOM_TMO_RST = 20'd2000;
	localparam logic [TMO_W-1:0] LOC_TMO_RST  = 20'd3000;
	localparam logic [TMO_W-1:0] NAV_TMO_RST  = 20'd5000;

	localparam int unsigned FAULT_ODOM = 0;
	localparam int unsigned FAULT_LOC  = 1;
	localparam int unsigned FAULT_NAV  = 2;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [TIME_W-1:0] time_ms;
		logic             goal_executing;
		logic [VEL_W-1:0] lin_x;
		logic [VEL_W-1:0] lin_y;
		logic [VEL_W-1:0] lin_z;
		logic [VEL_W-1:0] ang_x;
		logic [VEL_W-1:0] ang_y;
		logic [VEL_W-1:0] ang_z;
	} in_item_t;

	typedef struct packed {
		logic             vel_valid;
		logic [VEL_W-1:0] out_lin_x;
		logic [VEL_W-1:0] out_lin_y;
		logic [VEL_W-1:0] out_lin_z;
		logic [VEL_W-1:0] out_ang_x;
		logic [VEL_W-1:0] out_ang_y;
		logic [VEL_W-1:0] out_ang_z;
		logic             code_valid;
		logic [MASK_W-1:0] fault_mask;
		logic             stop_active;
	} out_item_t;

	typedef struct packed {
		logic [TMO_W-1:0] odom_tmo;
		logic [TMO_W-1:0] loc_tmo;
		logic [TMO_W-1:0] nav_tmo;
	} tmo_cfg_t;

endpackage
`default_nettype wire

/* rtl/hwe_cfg.sv */
`default_nettype none
module hwe_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [hwe_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [hwe_pkg::TMO_W-1:0]      wr_data,
	output hwe_pkg::tmo_cfg_t                   cfg
);

	hwe_pkg::tmo_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.odom_tmo <= hwe_pkg::ODOM_TMO_RST;
			cfg_q.loc_tmo  <= hwe_pkg::LOC_TMO_RST;
			cfg_q.nav_tmo  <= hwe_pkg::NAV_TMO_RST;
		end else if (wr_en) begin
			unique case (hwe_pkg::reg_idx_t'(wr_index))
				hwe_pkg::REG_ODOM_TMO: cfg_q.odom_tmo <= wr_data;
				hwe_pkg::REG_LOC_TMO:  cfg_q.loc_tmo  <= wr_data;
				hwe_pkg::REG_NAV_TMO:  cfg_q.nav_tmo  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* rtl/hwe_eval.sv */
`default_nettype none
module hwe_eval (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire hwe_pkg::in_item_t   item,
	input  wire hwe_pkg::tmo_cfg_t   cfg,
	output logic                     res_valid,
	output hwe_pkg::out_item_t       res
);

	logic odom_armed_q, loc_armed_q, nav_armed_q, nav_seen_q, stop_q;
	logic [hwe_pkg::TIME_W-1:0] odom_last_q, loc_last_q, nav_last_q;

	logic odom_armed_d, loc_armed_d, nav_armed_d, nav_seen_d, stop_d;
	logic odom_wr, loc_wr, nav_wr;

	logic [hwe_pkg::TIME_W-1:0] odom_el, loc_el, nav_el;
	logic [hwe_pkg::MASK_W-1:0] mask;
	logic all_seen;

	assign odom_el = item.time_ms - odom_last_q;
	assign loc_el  = item.time_ms - loc_last_q;
	assign nav_el  = item.time_ms - nav_last_q;

	always_comb begin
		mask = '0;
		mask[hwe_pkg::FAULT_ODOM] = odom_armed_q &&
			(odom_el > {{(hwe_pkg::TIME_W-hwe_pkg::TMO_W){1'b0}}, cfg.odom_tmo});
		mask[hwe_pkg::FAULT_LOC] = loc_armed_q &&
			(loc_el > {{(hwe_pkg::TIME_W-hwe_pkg::TMO_W){1'b0}}, cfg.loc_tmo});
		mask[hwe_pkg::FAULT_NAV] = nav_armed_q &&
			(nav_el > {{(hwe_pkg::TIME_W-hwe_pkg::TMO_W){1'b0}}, cfg.nav_tmo});
	end

	assign all_seen = odom_armed_q && loc_armed_q && nav_seen_q;

	always_comb begin
		odom_armed_d = odom_armed_q;
		loc_armed_d  = loc_armed_q;
		nav_armed_d  = nav_armed_q;
		nav_seen_d   = nav_seen_q;
		stop_d       = stop_q;
		odom_wr      = 1'b0;
		loc_wr       = 1'b0;
		nav_wr       = 1'b0;
		res_valid    = 1'b0;
		res          = '0;
		unique case (hwe_pkg::op_t'(item.opcode))
			hwe_pkg::OP_ODOM: begin
				odom_armed_d = 1'b1;
				odom_wr      = 1'b1;
			end
			hwe_pkg::OP_LOC: begin
				loc_armed_d = 1'b1;
				loc_wr      = 1'b1;
			end
			hwe_pkg::OP_NAV: begin
				if (item.goal_executing) begin
					nav_seen_d  = 1'b1;
					nav_armed_d = 1'b1;
					nav_wr      = 1'b1;
				end else begin
					nav_armed_d = 1'b0;
				end
			end
			hwe_pkg::OP_CHECK: begin
				if (mask[hwe_pkg::FAULT_ODOM]) odom_armed_d = 1'b0;
				if (mask[hwe_pkg::FAULT_LOC])  loc_armed_d  = 1'b0;
				if (mask[hwe_pkg::FAULT_NAV])  nav_armed_d  = 1'b0;
				if (mask != '0) begin
					stop_d          = 1'b1;
					res_valid       = 1'b1;
					res.vel_valid   = 1'b1;
					res.code_valid  = 1'b1;
					res.fault_mask  = mask;
					res.stop_active = 1'b1;
				end else if (all_seen) begin
					stop_d         = 1'b0;
					res_valid      = 1'b1;
					res.code_valid = 1'b1;
				end
			end
			hwe_pkg::OP_VEL: begin
				res_valid       = 1'b1;
				res.vel_valid   = 1'b1;
				res.stop_active = stop_q;
				if (!stop_q) begin
					res.out_lin_x = item.lin_x;
					res.out_lin_y = item.lin_y;
					res.out_lin_z = item.lin_z;
					res.out_ang_x = item.ang_x;
					res.out_ang_y = item.ang_y;
					res.out_ang_z = item.ang_z;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odom_armed_q <= 1'b0;
			loc_armed_q  <= 1'b0;
			nav_armed_q  <= 1'b0;
			nav_seen_q   <= 1'b0;
			stop_q       <= 1'b0;
		end else if (fire) begin
			odom_armed_q <= odom_armed_d;
			loc_armed_q  <= loc_armed_d;
			nav_armed_q  <= nav_armed_d;
			nav_seen_q   <= nav_seen_d;
			stop_q       <= stop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && odom_wr) odom_last_q <= item.time_ms;
		if (fire && loc_wr)  loc_last_q  <= item.time_ms;
		if (fire && nav_wr)  nav_last_q  <= item.time_ms;
	end

endmodule
`default_nettype wire

/* rtl/heartbeat_watchdog_estop_gate_top.sv */
// Heartbeat watchdog with emergency-stop velocity gate. Each request on the
// input channel is an odometry beat, a localization beat, a navigation
// status, a check tick or a velocity command, and produces at most one
// result. A request is registered on entry, evaluated against the channel
// flags and last-seen times, and its result is held in an output register;
// one request per cycle is taken while the output is drained, so throughput
// is one request per cycle, throttled only by out_ready. Timeouts are
// written on the cfg channel (index 0 odometry, 1 localization, 2 navigation)
// and take effect for the next request; write them only while no request is
// in flight.
`default_nettype none
module heartbeat_watchdog_estop_gate_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire hwe_pkg::in_item_t             in_item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output hwe_pkg::out_item_t                 out_item,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [hwe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hwe_pkg::TMO_W-1:0]     cfg_data
);

	hwe_pkg::tmo_cfg_t  cfg;
	hwe_pkg::in_item_t  item_s1;
	logic               valid_s1;
	logic               advance;
	logic               res_valid;
	hwe_pkg::out_item_t res;
	hwe_pkg::out_item_t out_q;
	logic               out_valid_q;

	assign cfg_ready = 1'b1;

	hwe_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_item;
	end

	hwe_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

/* dv/estop_gate_checker.sv */
`timescale 1ns / 1ps
module estop_gate_checker
	import hwe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_item,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_item,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TMO_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending
);

	logic [TMO_W-1:0] odom_limit;
	logic [TMO_W-1:0] loc_limit;
	logic [TMO_W-1:0] nav_limit;
	logic odom_live;
	logic loc_live;
	logic nav_live;
	logic nav_goal_seen;
	logic estop;
	logic [TIME_W-1:0] odom_stamp;
	logic [TIME_W-1:0] loc_stamp;
	logic [TIME_W-1:0] nav_stamp;
	out_item_t gate_results_q[$];
	out_item_t want_item;
	int fail_cnt;

	function automatic logic is_stale(logic [TIME_W-1:0] now, logic [TIME_W-1:0] stamp,
			logic [TMO_W-1:0] limit);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - stamp;
		return elapsed > {{(TIME_W-TMO_W){1'b0}}, limit};
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_cnt++;
		end
	endtask

	task automatic apply_request(input in_item_t req);
		out_item_t res;
		logic [MASK_W-1:0] mask;
		logic all_seen;
		res = '0;
		case (req.opcode)
			OP_ODOM: begin
				odom_live = 1'b1;
				odom_stamp = req.time_ms;
			end
			OP_LOC: begin
				loc_live = 1'b1;
				loc_stamp = req.time_ms;
			end
			OP_NAV: begin
				if (req.goal_executing) begin
					nav_goal_seen = 1'b1;
					nav_stamp = req.time_ms;
					nav_live = 1'b1;
				end else begin
					nav_live = 1'b0;
				end
			end
			OP_CHECK: begin
				all_seen = odom_live && loc_live && nav_goal_seen;
				mask = '0;
				if (odom_live && is_stale(req.time_ms, odom_stamp, odom_limit)) begin
					odom_live = 1'b0;
					mask[FAULT_ODOM] = 1'b1;
				end
				if (loc_live && is_stale(req.time_ms, loc_stamp, loc_limit)) begin
					loc_live = 1'b0;
					mask[FAULT_LOC] = 1'b1;
				end
				if (nav_live && is_stale(req.time_ms, nav_stamp, nav_limit)) begin
					nav_live = 1'b0;
					mask[FAULT_NAV] = 1'b1;
				end
				if (mask != '0) begin
					estop = 1'b1;
					res.vel_valid = 1'b1;
					res.code_valid = 1'b1;
					res.fault_mask = mask;
					res.stop_active = 1'b1;
					gate_results_q.push_back(res);
				end else if (all_seen) begin
					estop = 1'b0;
					res.code_valid = 1'b1;
					gate_results_q.push_back(res);
				end
			end
			OP_VEL: begin
				res.vel_valid = 1'b1;
				if (!estop) begin
					res.out_lin_x = req.lin_x;
					res.out_lin_y = req.lin_y;
					res.out_lin_z = req.lin_z;
					res.out_ang_x = req.ang_x;
					res.out_ang_y = req.ang_y;
					res.out_ang_z = req.ang_z;
				end
				res.stop_active = estop;
				gate_results_q.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odom_limit = ODOM_TMO_RST;
			loc_limit = LOC_TMO_RST;
			nav_limit = NAV_TMO_RST;
			odom_live = 1'b0;
			loc_live = 1'b0;
			nav_live = 1'b0;
			nav_goal_seen = 1'b0;
			estop = 1'b0;
			odom_stamp = '0;
			loc_stamp = '0;
			nav_stamp = '0;
			gate_results_q.delete();
			fail_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (gate_results_q.size() == 0) begin
					$error("result with no request pending: %p", out_item);
					fail_cnt++;
				end else begin
					want_item = gate_results_q.pop_front();
					check_field("vel_valid", want_item.vel_valid, out_item.vel_valid);
					check_field("out_lin_x", want_item.out_lin_x, out_item.out_lin_x);
					check_field("out_lin_y", want_item.out_lin_y, out_item.out_lin_y);
					check_field("out_lin_z", want_item.out_lin_z, out_item.out_lin_z);
					check_field("out_ang_x", want_item.out_ang_x, out_item.out_ang_x);
					check_field("out_ang_y", want_item.out_ang_y, out_item.out_ang_y);
					check_field("out_ang_z", want_item.out_ang_z, out_item.out_ang_z);
					check_field("code_valid", want_item.code_valid, out_item.code_valid);
					check_field("fault_mask", want_item.fault_mask, out_item.fault_mask);
					check_field("stop_active", want_item.stop_active, out_item.stop_active);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ODOM_TMO: odom_limit = cfg_data;
					REG_LOC_TMO: loc_limit = cfg_data;
					REG_NAV_TMO: nav_limit = cfg_data;
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				apply_request(in_item);
			errors <= fail_cnt;
			pending <= gate_results_q.size();
		end
	end

endmodule

/* dv/heartbeat_watchdog_estop_gate_top_test.sv */
`timescale 1ns / 1ps
module heartbeat_watchdog_estop_gate_top_test;
	import hwe_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam logic [TIME_W-1:0] T0 = 32'hFFFF_FC00;
	localparam logic [TIME_W-1:0] T1 = T0 + 32'd8000;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TMO_W-1:0] cfg_data = '0;
	int errors;
	int pending;
	int cycle_cnt = 0;
	int in_idle_pct = 38;
	int out_idle_pct = 38;
	logic [TIME_W-1:0] clock_ms;
	in_item_t req;

	heartbeat_watchdog_estop_gate_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	estop_gate_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("heartbeat_watchdog_estop_gate_top_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

	function automatic in_item_t fresh_request(logic [2:0] op, logic [TIME_W-1:0] t,
			logic goal);
		in_item_t r;
		r.opcode = op;
		r.time_ms = t;
		r.goal_executing = goal;
		r.lin_x = $urandom();
		r.lin_y = $urandom();
		r.lin_z = $urandom();
		r.ang_x = $urandom();
		r.ang_y = $urandom();
		r.ang_z = $urandom();
		return r;
	endfunction

	task automatic send_request(input in_item_t r);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TMO_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_limits(input logic [TMO_W-1:0] odom, input logic [TMO_W-1:0] loc,
			input logic [TMO_W-1:0] nav);
		settle();
		write_reg(REG_ODOM_TMO, odom);
		write_reg(REG_LOC_TMO, loc);
		write_reg(REG_NAV_TMO, nav);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_events(input int n_req, input int unsigned span);
		in_item_t r;
		int sent;
		int pick;
		sent = 0;
		clock_ms = $urandom();
		while (sent < n_req) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				clock_ms += $urandom_range(0, span / 2);
			else if (pick < 92)
				clock_ms += $urandom_range(0, span * 2);
			else if (pick < 96)
				clock_ms = $urandom();
			else
				clock_ms -= $urandom_range(1, span);
			r = fresh_request(OP_ODOM, clock_ms, $urandom_range(0, 99) < 70);
			pick = $urandom_range(0, 99);
			sent++;
			if (pick < 20)
				r.opcode = OP_ODOM;
			else if (pick < 40)
				r.opcode = OP_LOC;
			else if (pick < 55)
				r.opcode = OP_NAV;
			else if (pick < 75)
				r.opcode = OP_CHECK;
			else if (pick < 95)
				r.opcode = OP_VEL;
			else begin
				r.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				sent--;
			end
			send_request(r);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: 2000 / 3000 / 5000, times wrap through zero
		req = fresh_request(OP_VEL, T0, 1'b0);
		{req.lin_x, req.lin_y, req.lin_z, req.ang_x, req.ang_y, req.ang_z} = '1;
		send_request(req);
		send_request(fresh_request(OP_CHECK, T0, 1'b0));
		send_request(fresh_request(OP_ODOM, T0, 1'b0));
		send_request(fresh_request(OP_LOC, T0, 1'b1));
		send_request(fresh_request(OP_NAV, T0, 1'b1));
		send_request(fresh_request(OP_NAV, T0, 1'b0));
		// elapsed equal to limit is not a fault
		send_request(fresh_request(OP_CHECK, T0 + 32'd2000, 1'b0));
		send_request(fresh_request(OP_NAV, T0 + 32'd2000, 1'b1));
		send_request(fresh_request(OP_CHECK, T0 + 32'd2001, 1'b0));
		send_request(fresh_request(OP_VEL, T0 + 32'd2001, 1'b0));
		send_request(fresh_request(OP_CHECK, T0 + 32'd3001, 1'b0));
		send_request(fresh_request(OP_CHECK, T0 + 32'd7001, 1'b0));
		send_request(fresh_request(OP_ODOM, T1, 1'b0));
		send_request(fresh_request(OP_LOC, T1, 1'b0));
		send_request(fresh_request(OP_NAV, T1, 1'b1));
		send_request(fresh_request(OP_CHECK, T1 + 32'd5001, 1'b0));
		req = fresh_request(OP_VEL, T1 + 32'd5001, 1'b1);
		{req.lin_x, req.lin_y, req.lin_z, req.ang_x, req.ang_y, req.ang_z} = '0;
		send_request(req);
		send_request(fresh_request(OP_ODOM, T1 + 32'd6000, 1'b0));
		send_request(fresh_request(OP_LOC, T1 + 32'd6000, 1'b0));
		send_request(fresh_request(OP_CHECK, T1 + 32'd6000, 1'b0));
		req.opcode = OP_VEL;
		send_request(req);
		send_request(fresh_request(OP_VEL, T1 + 32'd6001, 1'b0));
		send_request(fresh_request(OP_UNUSED_LO, T1, 1'b1));
		send_request(fresh_request(OP_UNUSED_HI, '1, 1'b1));
		// time going backwards looks like a huge elapsed time
		send_request(fresh_request(OP_CHECK, '0, 1'b0));

		set_limits(20'd1, 20'd1, 20'd1);
		@(posedge clk);
		write_reg(REG_UNUSED, '1);
		cfg_valid <= 1'b0;
		run_events(130, 4);

		set_limits('0, '1, 20'd1000000);
		run_events(130, 600000);

		set_limits(ODOM_TMO_RST, LOC_TMO_RST, NAV_TMO_RST);
		in_idle_pct = 0;
		out_idle_pct = 0;
		run_events(130, 3000);
		in_idle_pct = 38;
		out_idle_pct = 38;

		set_limits(20'($urandom_range(100, 20000)), 20'($urandom_range(100, 20000)),
			20'($urandom_range(100, 20000)));
		run_events(130, 8000);

		set_limits(20'($urandom_range(1, 1000000)), 20'($urandom_range(1, 1000000)),
			20'($urandom_range(1, 1000000)));
		run_events(130, 500000);

		settle();
		if (errors == 0 && pending == 0)
			$display("heartbeat_watchdog_estop_gate_top_test: done, clean");
		else
			$display("heartbeat_watchdog_estop_gate_top_test: done, errors");
		$finish;
	end

endmodule
